### sv/lkvc_pkg.sv
// Shared types and constants of the LRU key-value cache.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

   // Field and register widths fixed by the interface
   localparam int FIELD_W    = 32;
   localparam int CFG_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register file
   localparam logic             REG_CAPACITY = 1'b0;
   localparam logic [CFG_W-1:0] CFG_RESET    = 5'd16;

   // Request operations
   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   // Read value returned on a miss
   localparam logic [FIELD_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch the request and its lookup result
      logic commit;    // apply the update of the held request
      logic load_rsp;  // load the response register
   } lkvc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_get;
   } lkvc_sts_type;

endpackage

`default_nettype wire

### sv/lkvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; hold data while not reading
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/lkvc_ctrl.sv
// Controller of the LRU key-value cache: request/response handshake and sequencing.
// Depends on lkvc_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl
   import lkvc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   input  wire lkvc_sts_type sts,
   output lkvc_cmd_type      cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_busy;

   // Take a request only while nothing is in flight
   assign req_stall = (state_ff != ST_IDLE);
   assign out_busy  = rsp_valid_ff && rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // A get waits for room in the response register
            if (!(sts.is_get && out_busy)) begin
               cmd.commit   = 1'b1;
               cmd.load_rsp = sts.is_get;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on load, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("response loaded over a stalled response");
   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_EXEC))
      else $error("captured request not executed next cycle");
   a_commit_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE) && !cmd.commit)
      else $error("request committed twice");
`endif

endmodule

`default_nettype wire

### sv/lkvc_dp.sv
// Datapath of the LRU key-value cache: key slots, age ranks, value RAM, response register.
// Depends on lkvc_pkg and lkvc_ram.
`timescale 1ns / 1ps
`default_nettype none

module lkvc_dp
   import lkvc_pkg::*;
#(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lkvc_cmd_type               cmd,
   output lkvc_sts_type                    sts,
   input  wire logic [CFG_W-1:0]           capacity,
   input  wire logic                       req_mode,
   input  wire logic signed [FIELD_W-1:0]  req_lookup_key,
   input  wire logic signed [FIELD_W-1:0]  req_write_value,
   output logic                            rsp_hit,
   output logic signed [FIELD_W-1:0]       rsp_read_value
);

   localparam int KW   = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
   localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int CAPW = (CW > CFG_W) ? CW : CFG_W;

   // Slot state
   logic [KW-1:0]      slot_key_ff  [ENTRIES];
   logic [KW-1:0]      slot_key_in  [ENTRIES];
   logic [IW-1:0]      rank_ff      [ENTRIES];
   logic [IW-1:0]      rank_in      [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]      count_ff, count_in;

   // Held request
   logic               mode_ff;
   logic [KW-1:0]      key_ff;
   logic [FIELD_W-1:0] value_ff;
   logic               hit_ff;
   logic [IW-1:0]      slot_ff;
   logic [IW-1:0]      hit_rank_ff;

   // Response register
   logic               rsp_hit_ff;
   logic [FIELD_W-1:0] rsp_value_ff;

   // Lookup and replacement logic
   logic [KW-1:0]      req_key;
   logic [ENTRIES-1:0] match;
   logic               hit_any;
   logic [IW-1:0]      match_idx;
   logic [IW-1:0]      match_rank;
   logic [CAPW-1:0]    cap_raw, cap, cap_m1;
   logic               full;
   logic [ENTRIES-1:0] evict, kept, free_oh;
   logic [IW-1:0]      free_idx;

   // Value RAM ports
   logic               ram_we;
   logic [IW-1:0]      ram_waddr;
   logic [FIELD_W-1:0] ram_rdata;

   // Compare the incoming key against every slot; keys are unique among valid slots
   assign req_key = KW'($unsigned(req_lookup_key));

   always_comb begin
      match_idx  = '0;
      match_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (slot_key_ff[i] == req_key);
         if (match[i]) begin
            match_idx  = match_idx | IW'(i);
            match_rank = match_rank | rank_ff[i];
         end
      end
      hit_any = |match;
   end

   // Effective capacity: zero acts as one, clamp to the slot count
   always_comb begin
      cap_raw = CAPW'(capacity);
      if (capacity == '0) begin
         cap = CAPW'(1);
      end else if (cap_raw > CAPW'(ENTRIES)) begin
         cap = CAPW'(ENTRIES);
      end else begin
         cap = cap_raw;
      end
      cap_m1 = cap - CAPW'(1);
      full   = CAPW'(count_ff) >= cap;
   end

   // When full, evict every entry ranked at or past capacity-1, then pick the lowest free slot
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         evict[i] = full && valid_ff[i] && (CAPW'(rank_ff[i]) >= cap_m1);
      end
      kept    = valid_ff & ~evict;
      free_oh = ~kept & (kept + ENTRIES'(1));
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (free_oh[i]) begin
            free_idx = free_idx | IW'(i);
         end
      end
   end

   // Next slot state
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_key_in[i] = slot_key_ff[i];
         rank_in[i]     = rank_ff[i];
      end
      if (cmd.commit) begin
         if (hit_ff) begin
            // Touch: entries more recent than the hit age by one
            for (int i = 0; i < ENTRIES; i++) begin
               if (IW'(i) == slot_ff) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + IW'(1);
               end
            end
         end else if (mode_ff == MODE_PUT) begin
            // Insert as most recent; survivors age by one
            for (int i = 0; i < ENTRIES; i++) begin
               if (free_oh[i]) begin
                  valid_in[i]    = 1'b1;
                  slot_key_in[i] = key_ff;
                  rank_in[i]     = '0;
               end else if (kept[i]) begin
                  rank_in[i] = rank_ff[i] + IW'(1);
               end else if (evict[i]) begin
                  valid_in[i] = 1'b0;
                  rank_in[i]  = '0;
               end
            end
            count_in = full ? CW'(cap) : count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         slot_key_ff[i] <= slot_key_in[i];
      end
   end

   // Hold the request and its lookup result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req_mode;
         key_ff      <= req_key;
         value_ff    <= $unsigned(req_write_value);
         hit_ff      <= hit_any;
         slot_ff     <= match_idx;
         hit_rank_ff <= match_rank;
      end
   end

   // Value store: read on capture, write on put commit
   assign ram_we    = cmd.commit && (mode_ff == MODE_PUT);
   assign ram_waddr = hit_ff ? slot_ff : free_idx;

   lkvc_ram #(
      .WIDTH (FIELD_W),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (value_ff),
      .rd_en   (cmd.capture),
      .rd_addr (match_idx),
      .rd_data (ram_rdata)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_hit_ff   <= hit_ff;
         rsp_value_ff <= hit_ff ? ram_rdata : MISS_VALUE;
      end
   end

   assign sts.is_get     = (mode_ff == MODE_GET);
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = $signed(rsp_value_ff);

`ifndef SYNTHESIS
   a_keys_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("key held in more than one valid slot");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("entry count beyond slot count");
   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !hit_ff && (mode_ff == MODE_PUT)) |=> (count_ff != '0))
      else $error("insert left the store empty");
`endif

endmodule

`default_nettype wire

### sv/lru_key_value_cache_unit.sv
// LRU key-value cache: a fully associative store of ENTRIES key/value pairs with
// least-recently-used replacement. Each request is a get (mode 0) or a put (mode 1).
// A get returns one response: hit and the stored value, or hit clear and all ones;
// a put returns none. Each request is accepted in the idle state, which compares the
// key against all slots in parallel and reads the value RAM; the execute state then
// updates the age ranks and writes the RAM. A get waits in the execute state while the
// response register still holds a stalled response. The capacity register (byte
// address 0, reset 16) sets how many entries are held before eviction; write it only
// while idle. The store is empty after reset with no clearing pass.
// Depends on lkvc_pkg, lkvc_ctrl, lkvc_dp and lkvc_ram.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_unit
   import lkvc_pkg::*;
#(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_mode,
   input  wire logic signed [FIELD_W-1:0]  req_lookup_key,
   input  wire logic signed [FIELD_W-1:0]  req_write_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_hit,
   output logic signed [FIELD_W-1:0]       rsp_read_value,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [CSR_ADDR_W-1:0]      paddr,
   input  wire logic [CSR_DATA_W-1:0]      pwdata,
   output logic [CSR_DATA_W-1:0]           prdata,
   output logic                            pready
);

   lkvc_cmd_type     cmd;
   lkvc_sts_type     sts;
   logic [CFG_W-1:0] capacity_ff, capacity_in;
   logic             csr_wr;

   // Register access: one register, word index in paddr bit 2
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr) begin
         capacity_in = pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CFG_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata = (paddr[2] == REG_CAPACITY) ? CSR_DATA_W'(capacity_ff) : '0;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lkvc_dp #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .capacity        (capacity_ff),
      .req_mode        (req_mode),
      .req_lookup_key  (req_lookup_key),
      .req_write_value (req_write_value),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value)
   );

endmodule

`default_nettype wire
